/* sv/rrps_pkg.sv */
package rrps_pkg;

	localparam int RailCountDefault = 6;
	localparam int FullTurn = 36000;
	localparam int HalfTurn = 18000;
	localparam int DutyScale = 409600;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_ROT   = 2'd1;
	localparam logic [1:0] MODE_PLACE = 2'd2;

	localparam logic [2:0] REG_TEMP   = 3'd0;
	localparam logic [2:0] REG_COOL   = 3'd1;
	localparam logic [2:0] REG_PLACER = 3'd2;
	localparam logic [2:0] REG_GP     = 3'd3;
	localparam logic [2:0] REG_GI     = 3'd4;
	localparam logic [2:0] REG_GD     = 3'd5;
	localparam logic [2:0] REG_FLOOR  = 3'd6;
	localparam logic [2:0] REG_CEIL   = 3'd7;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        launch;
		logic signed [11:0] temp_dc;
		logic        aligned;
		logic [15:0] angle_cdeg;
	} item_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        motor_on;
		logic [15:0] motor_duty;
		logic        placer_on;
		logic [2:0]  used_rails;
	} result_t;

	typedef struct packed {
		logic signed [11:0] temp_threshold;
		logic [31:0] cooling_time_ms;
		logic [31:0] placer_time_ms;
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [15:0] duty_floor;
		logic [15:0] duty_ceiling;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input item
		logic purge_step; // examine one queue entry
		logic purge_done; // commit compacted count
		logic decide;     // evaluate the state machine step
		logic pid_step;   // advance the PID unit by one step
		logic finish;     // register the result
	} cmd_t;

	typedef struct packed {
		logic purge_last;
		logic need_pid;
		logic pid_last;
	} status_t;

endpackage

/* sv/rrps_ctrl.sv */
module rrps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_taken,
	input  rrps_pkg::status_t sts,
	output rrps_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             res_valid
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PURGE = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_PID   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q;
	logic       res_valid_q;

	// The result register is only loaded once the previous result has left.
	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		unique case (state_q)
			S_PURGE: begin
				cmd.purge_step = 1'b1;
				cmd.purge_done = sts.purge_last;
			end
			S_DEC:   cmd.decide = 1'b1;
			S_PID:   cmd.pid_step = 1'b1;
			S_FIN:   cmd.finish = !res_valid_q || out_taken;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) res_valid_q <= 1'b1;
			else if (out_taken) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:  if (in_fire) state_q <= S_PURGE;
				S_PURGE: if (sts.purge_last) state_q <= S_DEC;
				S_DEC:   state_q <= sts.need_pid ? S_PID : S_FIN;
				S_PID:   if (sts.pid_last) state_q <= S_FIN;
				S_FIN:   if (cmd.finish) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
endmodule

/* sv/rrps_datapath.sv */
module rrps_datapath #(
	parameter int RAIL_COUNT = rrps_pkg::RailCountDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rrps_pkg::item_t   item,
	input  rrps_pkg::cfg_t    cfg,
	input  rrps_pkg::cmd_t    cmd,
	output rrps_pkg::status_t sts,
	output rrps_pkg::result_t res
);
	localparam int IW = $clog2(RAIL_COUNT);
	localparam int CW = $clog2(RAIL_COUNT + 1);
	// The duty scale is 25 * 2^14. Below 65536 times the scale the magnitude
	// shifted right by 14 fits in 21 bits, and a multiply by ceil(2^26 / 25)
	// followed by dropping 26 bits gives the exact quotient by 25 there.
	// Larger magnitudes only have to read as above any ceiling.
	localparam logic [47:0] BigMag = 48'(65536) * 48'(rrps_pkg::DutyScale);
	localparam logic [21:0] RecipDuty = 22'd2684355;

	rrps_pkg::item_t itm_q;
	logic [1:0]   mode_q;
	logic         left_zone_q, motor_en_q, placer_en_q;
	logic [31:0]  stamps_q [RAIL_COUNT];
	logic [CW-1:0] count_q, rd_q, wr_q;
	logic [31:0]  placer_start_q;
	logic [15:0]  duty_q;
	logic signed [15:0] ep1_q, ep2_q, e_q;
	logic signed [47:0] acc_q;
	logic [2:0]   pstep_q;
	logic signed [35:0] prod_q;
	logic [47:0]  mag_q;
	logic         big_q;
	logic [42:0]  recip_q;
	logic [16:0]  quot;
	rrps_pkg::result_t res_q;

	// Sector target: the sector is found by comparing against constant
	// boundaries, and the next boundary angle comes from a constant table.
	logic [15:0] ang;
	logic [IW-1:0] sector, nxt;
	logic [15:0] tgt;
	logic signed [17:0] e_raw;
	logic signed [15:0] e_wr;
	logic [35:0] secprod;
	always_comb begin
		ang = (itm_q.angle_cdeg >= 16'(rrps_pkg::FullTurn))
			? itm_q.angle_cdeg - 16'(rrps_pkg::FullTurn) : itm_q.angle_cdeg;
		secprod = 36'(ang) * 36'(RAIL_COUNT);
		sector = '0;
		for (int k = 1; k < RAIL_COUNT; k++)
			if (secprod >= 36'(k * rrps_pkg::FullTurn)) sector = IW'(k);
		nxt = (sector == IW'(RAIL_COUNT - 1)) ? '0 : sector + 1'b1;
		tgt = '0;
		for (int k = 0; k < RAIL_COUNT; k++)
			if (nxt == IW'(k)) tgt = 16'((k * rrps_pkg::FullTurn) / RAIL_COUNT);
		e_raw = 18'(signed'({2'b0, tgt})) - 18'(signed'({2'b0, ang}));
		if (e_raw > 18'(rrps_pkg::HalfTurn)) e_raw = e_raw - 18'(rrps_pkg::FullTurn);
		else if (e_raw < -18'(rrps_pkg::HalfTurn)) e_raw = e_raw + 18'(rrps_pkg::FullTurn);
		e_wr = e_raw[15:0];
	end

	logic cool_ok;
	logic [31:0] rd_stamp;
	assign rd_stamp = stamps_q[rd_q[IW-1:0]];
	assign cool_ok = (itm_q.now_ms - rd_stamp) < cfg.cooling_time_ms;
	assign sts.purge_last = (rd_q >= count_q) || (rd_q == CW'(RAIL_COUNT - 1));

	// PID unit steps: 0 forms A0*e, 1 to 3 accumulate the products with
	// saturation, 4 takes the magnitude and shifts the error history, 5 scales
	// by the reciprocal of the duty scale, 6 clamps into the duty range.
	logic signed [18:0] coef;
	logic signed [15:0] opnd;
	logic signed [49:0] sum;
	logic signed [47:0] acc_sat;
	always_comb begin
		unique case (pstep_q)
			3'd0: begin coef = 19'(cfg.gain_p) + 19'(cfg.gain_i) + 19'(cfg.gain_d); opnd = e_q; end
			3'd1: begin coef = -(19'(cfg.gain_p) + 19'({cfg.gain_d, 1'b0})); opnd = ep1_q; end
			default: begin coef = 19'(cfg.gain_d); opnd = ep2_q; end
		endcase
	end
	assign sum = 50'(acc_q) + 50'(prod_q);
	always_comb begin
		if (sum > 50'sh0_7FFF_FFFF_FFFF) acc_sat = 48'sh7FFF_FFFF_FFFF;
		else if (sum < -50'sh0_8000_0000_0000) acc_sat = 48'sh8000_0000_0000;
		else acc_sat = sum[47:0];
	end
	assign sts.pid_last = (pstep_q == 3'd6);
	assign quot = big_q ? 17'h1FFFF : recip_q[42:26];

	logic need;
	always_comb begin
		need = 1'b0;
		if (mode_q == rrps_pkg::MODE_IDLE)
			need = itm_q.launch && (count_q < CW'(RAIL_COUNT)) &&
				!((itm_q.temp_dc < cfg.temp_threshold) && itm_q.aligned);
		else if (mode_q == rrps_pkg::MODE_ROT)
			need = !itm_q.aligned || !left_zone_q;
	end
	assign sts.need_pid = need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rrps_pkg::MODE_IDLE;
			left_zone_q <= 1'b0; motor_en_q <= 1'b0; placer_en_q <= 1'b0;
			count_q <= '0; rd_q <= '0; wr_q <= '0;
			placer_start_q <= '0; duty_q <= '0;
			ep1_q <= '0; ep2_q <= '0; acc_q <= '0; pstep_q <= '0;
		end else begin
			if (cmd.load) begin
				rd_q <= '0; wr_q <= '0;
			end
			if (cmd.purge_step && rd_q < count_q) begin
				if (cool_ok) begin
					stamps_q[wr_q[IW-1:0]] <= rd_stamp;
					wr_q <= wr_q + 1'b1;
				end
				rd_q <= rd_q + 1'b1;
			end
			if (cmd.purge_done)
				count_q <= (rd_q < count_q && cool_ok) ? wr_q + 1'b1 : wr_q;
			if (cmd.decide) begin
				pstep_q <= '0;
				e_q <= e_wr;
				unique case (mode_q)
					rrps_pkg::MODE_IDLE: if (itm_q.launch && count_q < CW'(RAIL_COUNT)) begin
						if (!need) begin
							placer_en_q <= 1'b1; placer_start_q <= itm_q.now_ms;
							mode_q <= rrps_pkg::MODE_PLACE;
						end else begin
							mode_q <= rrps_pkg::MODE_ROT; left_zone_q <= 1'b0;
							motor_en_q <= 1'b1;
						end
					end
					rrps_pkg::MODE_ROT: begin
						if (!itm_q.aligned) begin
							left_zone_q <= 1'b1; motor_en_q <= 1'b1;
						end else if (left_zone_q) begin
							motor_en_q <= 1'b0;
							if (count_q < CW'(RAIL_COUNT)) begin
								stamps_q[count_q[IW-1:0]] <= itm_q.now_ms;
								count_q <= count_q + 1'b1;
							end
							placer_en_q <= 1'b1; placer_start_q <= itm_q.now_ms;
							left_zone_q <= 1'b0; mode_q <= rrps_pkg::MODE_PLACE;
						end else motor_en_q <= 1'b1;
					end
					rrps_pkg::MODE_PLACE:
						if ((itm_q.now_ms - placer_start_q) >= cfg.placer_time_ms) begin
							placer_en_q <= 1'b0; mode_q <= rrps_pkg::MODE_IDLE;
						end
					default: ;
				endcase
			end
			if (cmd.pid_step) begin
				pstep_q <= pstep_q + 3'd1;
				unique case (pstep_q)
					3'd0, 3'd1, 3'd2: prod_q <= 36'(coef) * 36'(opnd);
					default: ;
				endcase
				if (pstep_q >= 3'd1 && pstep_q <= 3'd3) acc_q <= acc_sat;
				if (pstep_q == 3'd4) begin
					mag_q <= acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
					ep2_q <= ep1_q; ep1_q <= e_q;
				end
				if (pstep_q == 3'd5) begin
					big_q <= (mag_q >= BigMag);
					recip_q <= 43'(mag_q[34:14]) * 43'(RecipDuty);
				end
				if (pstep_q == 3'd6) begin
					if (quot > 17'(cfg.duty_ceiling)) duty_q <= cfg.duty_ceiling;
					else if (quot < 17'(cfg.duty_floor))
						duty_q <= (cfg.duty_floor > cfg.duty_ceiling) ? cfg.duty_ceiling
							: cfg.duty_floor;
					else duty_q <= quot[15:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) itm_q <= item;
		if (cmd.finish) begin
			res_q.mode <= mode_q;
			res_q.motor_on <= motor_en_q;
			res_q.motor_duty <= duty_q;
			res_q.placer_on <= placer_en_q;
			res_q.used_rails <= 3'(count_q);
		end
	end
	assign res = res_q;
endmodule

/* sv/rail_rotate_place_sequencer_unit.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tdata: now_ms, temp_dc, angle_cdeg; tuser: launch, aligned
// m_axis    | out       | tdata: mode, motor_on, motor_duty, placer_on, used_rails
// apb       | in/out    | eight configuration registers at byte address 4*i
// After a transfer in, the unit examines the stored stamps, at most RAIL_COUNT,
// and keeps those still cooling, then takes a decision step, runs the PID unit
// steps when the wheel is driven, and posts the result; the next transfer in
// can be taken the cycle after the post. A result still waiting on m_axis holds
// the next tick in its posting cycle, and with it s_axis_tready low.
// Reset (arst_n low) returns idle mode, an empty queue and reset registers.
module rail_rotate_place_sequencer_unit #(
	parameter int RAIL_COUNT = rrps_pkg::RailCountDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // now_ms[31:0], temp_dc[43:32], angle_cdeg[59:44]
	input  logic [1:0]  s_axis_tuser,  // launch[0], aligned[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // mode[1:0], motor_on[2], motor_duty[18:3],
	                                   // placer_on[19], used_rails[22:20]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	rrps_pkg::cfg_t    cfg_q;
	rrps_pkg::item_t   item;
	rrps_pkg::cmd_t    cmd;
	rrps_pkg::status_t sts;
	rrps_pkg::result_t res;
	logic busy, in_fire, out_taken;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	// Registers are written on the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_threshold <= 12'sd230;
			cfg_q.cooling_time_ms <= 32'd10000;
			cfg_q.placer_time_ms <= 32'd500;
			cfg_q.gain_p <= 16'd24576;
			cfg_q.gain_i <= 16'd82;
			cfg_q.gain_d <= 16'd1434;
			cfg_q.duty_floor <= 16'd1469;
			cfg_q.duty_ceiling <= 16'd1889;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				rrps_pkg::REG_TEMP:   cfg_q.temp_threshold <= pwdata[11:0];
				rrps_pkg::REG_COOL:   cfg_q.cooling_time_ms <= pwdata;
				rrps_pkg::REG_PLACER: cfg_q.placer_time_ms <= pwdata;
				rrps_pkg::REG_GP:     cfg_q.gain_p <= pwdata[15:0];
				rrps_pkg::REG_GI:     cfg_q.gain_i <= pwdata[15:0];
				rrps_pkg::REG_GD:     cfg_q.gain_d <= pwdata[15:0];
				rrps_pkg::REG_FLOOR:  cfg_q.duty_floor <= pwdata[15:0];
				rrps_pkg::REG_CEIL:   cfg_q.duty_ceiling <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			rrps_pkg::REG_TEMP:   prdata = 32'(signed'(cfg_q.temp_threshold));
			rrps_pkg::REG_COOL:   prdata = cfg_q.cooling_time_ms;
			rrps_pkg::REG_PLACER: prdata = cfg_q.placer_time_ms;
			rrps_pkg::REG_GP:     prdata = 32'(cfg_q.gain_p);
			rrps_pkg::REG_GI:     prdata = 32'(cfg_q.gain_i);
			rrps_pkg::REG_GD:     prdata = 32'(cfg_q.gain_d);
			rrps_pkg::REG_FLOOR:  prdata = 32'(cfg_q.duty_floor);
			rrps_pkg::REG_CEIL:   prdata = 32'(cfg_q.duty_ceiling);
			default:              prdata = '0;
		endcase
	end

	assign item.now_ms = s_axis_tdata[31:0];
	assign item.temp_dc = s_axis_tdata[43:32];
	assign item.angle_cdeg = s_axis_tdata[59:44];
	assign item.launch = s_axis_tuser[0];
	assign item.aligned = s_axis_tuser[1];

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_taken = m_axis_tvalid && m_axis_tready;

	rrps_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_taken, .sts, .cmd, .busy,
		.res_valid(m_axis_tvalid)
	);

	rrps_datapath #(.RAIL_COUNT(RAIL_COUNT)) u_dp (
		.clk, .arst_n, .item, .cfg(cfg_q), .cmd, .sts, .res
	);

	assign m_axis_tdata = {1'b0, res.used_rails, res.placer_on, res.motor_duty,
		res.motor_on, res.mode};
endmodule

/* sv/rrps_checker.sv */
module rrps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);
	// The mode code is never the unused value.
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)) else $error("bad mode");
	// A transfer in is never taken in the cycle right after another.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("no gap");
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("hold");
	// Placing mode never drives the wheel.
	a_place: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] == 2'd2) |-> !m_axis_tdata[2])
		else $error("motor in place");
endmodule

bind rail_rotate_place_sequencer_unit rrps_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
	.m_axis_tdata
);
